FILE: hw/rtl/adsr_pkg.sv
// Shared types and constants for the ADSR envelope generator.
`timescale 1ns / 1ps
`default_nettype none

package adsr_pkg;

  // Level format: unsigned Q1.23, unity is 1 << LEVEL_FRAC_BITS
  localparam int LEVEL_FRAC_BITS = 23;
  localparam int LVL_W           = LEVEL_FRAC_BITS + 1;
  localparam int CFG_IDX_W       = 3;

  localparam logic [LVL_W-1:0] UNITY = LVL_W'(1) << LEVEL_FRAC_BITS;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    REQ_SAMPLE   = 2'd0,
    REQ_NOTE_ON  = 2'd1,
    REQ_NOTE_OFF = 2'd2
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATTACK_STEP  = 3'd0,
    CFG_PEAK_LEVEL   = 3'd1,
    CFG_DECAY_STEP   = 3'd2,
    CFG_HOLD_LEVEL   = 3'd3,
    CFG_RELEASE_STEP = 3'd4
  } cfg_idx_t;

  // Programmed envelope shape
  typedef struct packed {
    logic [LVL_W-1:0] attack_step;
    logic [LVL_W-1:0] peak_level;
    logic [LVL_W-1:0] decay_step;
    logic [LVL_W-1:0] hold_level;
    logic [LVL_W-1:0] release_step;
  } env_cfg_t;

  // Envelope state
  typedef struct packed {
    phase_t           phase;
    logic [LVL_W-1:0] level;
  } env_state_t;

  function automatic logic [LVL_W-1:0] sat_unity(input logic [LVL_W-1:0] v);
    return (v > UNITY) ? UNITY : v;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/adsr_step.sv
// Next-state logic of the envelope: note events and the per-sample level step.
`timescale 1ns / 1ps
`default_nettype none

module adsr_step (
  input  wire adsr_pkg::env_cfg_t   cfg,
  input  wire adsr_pkg::env_state_t cur,
  input  wire [1:0]                 req_type,
  output adsr_pkg::env_state_t      nxt,
  output logic                      emit
);

  logic [adsr_pkg::LVL_W-1:0] peak;
  logic [adsr_pkg::LVL_W-1:0] hold;
  logic [adsr_pkg::LVL_W:0]   atk_sum;
  logic [adsr_pkg::LVL_W-1:0] above_hold;
  adsr_pkg::env_state_t       stepped;

  assign peak       = adsr_pkg::sat_unity(cfg.peak_level);
  assign hold       = adsr_pkg::sat_unity(cfg.hold_level);
  assign atk_sum    = {1'b0, cur.level} + {1'b0, cfg.attack_step};
  assign above_hold = cur.level - hold;

  always_comb begin
    stepped = cur;
    case (cur.phase)
      adsr_pkg::PH_ATTACK: begin
        if (atk_sum >= {1'b0, peak}) begin
          stepped.level = peak;
          stepped.phase = adsr_pkg::PH_DECAY;
        end else begin
          stepped.level = atk_sum[adsr_pkg::LVL_W-1:0];
        end
      end
      adsr_pkg::PH_DECAY: begin
        // at or below hold snaps up to hold
        if (cur.level <= hold || above_hold <= cfg.decay_step) begin
          stepped.level = hold;
          stepped.phase = adsr_pkg::PH_SUSTAIN;
        end else begin
          stepped.level = cur.level - cfg.decay_step;
        end
      end
      adsr_pkg::PH_SUSTAIN: begin
        stepped.level = hold;
      end
      adsr_pkg::PH_RELEASE: begin
        if (cur.level <= cfg.release_step) begin
          stepped.level = '0;
          stepped.phase = adsr_pkg::PH_IDLE;
        end else begin
          stepped.level = cur.level - cfg.release_step;
        end
      end
      default: begin
        stepped = cur;
      end
    endcase
  end

  always_comb begin
    nxt  = cur;
    emit = 1'b0;
    case (req_type)
      adsr_pkg::REQ_SAMPLE: begin
        nxt  = stepped;
        emit = 1'b1;
      end
      adsr_pkg::REQ_NOTE_ON: begin
        nxt.phase = adsr_pkg::PH_ATTACK;
      end
      adsr_pkg::REQ_NOTE_OFF: begin
        nxt.phase = adsr_pkg::PH_RELEASE;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/adsr_envelope_generator.sv
// Top level of the linear ADSR envelope generator: state, sample pipeline, config.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Transfer                Payload
// in_      in   in_valid & in_ready     in_req_type, in_sample_in
// out_     out  out_valid & out_ready   out_sample_out, out_env_level, out_env_phase
// cfg_     in   cfg_we                  cfg_idx, cfg_wdata
//
// One item per cycle sustained while the output is not stalled. Envelope phase/level
// update in the cycle of the input transfer (one add, one compare). Audio samples
// then pass stage 1, which holds sample and level, and the output register; the
// multiply sits between stage 1 and the output register.
// Note events update state only and produce no output transfer.
// Synchronous active-low reset: phase idle, level zero, registers to defaults.
// Output stall backs up through stage 1 to in_ready; no transfer is dropped.

module adsr_envelope_generator #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire                                clk,
  input  wire                                rst_n,

  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire  [1:0]                         in_req_type,
  input  wire  signed [SAMPLE_BITS-1:0]      in_sample_in,

  output logic                               out_valid,
  input  wire                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]      out_sample_out,
  output logic [adsr_pkg::LVL_W-1:0]         out_env_level,
  output logic [2:0]                         out_env_phase,

  input  wire                                cfg_we,
  input  wire  [adsr_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire  [adsr_pkg::LVL_W-1:0]         cfg_wdata
);

  localparam int PROD_W = SAMPLE_BITS + adsr_pkg::LVL_W + 1;

  // Config registers
  adsr_pkg::env_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_step  <= adsr_pkg::LVL_W'(175);
      cfg_r.peak_level   <= adsr_pkg::UNITY;
      cfg_r.decay_step   <= '0;
      cfg_r.hold_level   <= adsr_pkg::UNITY;
      cfg_r.release_step <= adsr_pkg::LVL_W'(175);
    end else if (cfg_we) begin
      case (cfg_idx)
        adsr_pkg::CFG_ATTACK_STEP:  cfg_r.attack_step  <= cfg_wdata;
        adsr_pkg::CFG_PEAK_LEVEL:   cfg_r.peak_level   <= cfg_wdata;
        adsr_pkg::CFG_DECAY_STEP:   cfg_r.decay_step   <= cfg_wdata;
        adsr_pkg::CFG_HOLD_LEVEL:   cfg_r.hold_level   <= cfg_wdata;
        adsr_pkg::CFG_RELEASE_STEP: cfg_r.release_step <= cfg_wdata;
        default: ; // unmapped index, dropped
      endcase
    end
  end

  // Envelope state
  adsr_pkg::env_state_t st_r;
  adsr_pkg::env_state_t st_nxt;
  logic                 emit;
  logic                 in_xfer;

  adsr_step u_step (
    .cfg      (cfg_r),
    .cur      (st_r),
    .req_type (in_req_type),
    .nxt      (st_nxt),
    .emit     (emit)
  );

  // Pipeline flow control
  logic s1_v_r;
  logic out_valid_r;
  logic out_load;
  logic s1_adv;

  assign out_load = !out_valid_r || out_ready;
  assign s1_adv   = s1_v_r && out_load;
  assign in_ready = !s1_v_r || s1_adv;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase <= adsr_pkg::PH_IDLE;
      st_r.level <= '0;
    end else if (in_xfer) begin
      st_r <= st_nxt;
    end
  end

  // Stage 1: sample and stepped level
  logic signed [SAMPLE_BITS-1:0]      s1_sample_r;
  adsr_pkg::env_state_t               s1_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_xfer && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      s1_sample_r <= in_sample_in;
      s1_st_r     <= st_nxt;
    end
  end

  // Scale: floor(sample * level / 2^frac), low SAMPLE_BITS kept
  logic signed [PROD_W-1:0] prod;

  assign prod = PROD_W'(s1_sample_r) * PROD_W'($signed({1'b0, s1_st_r.level}));

  // Output register
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic [adsr_pkg::LVL_W-1:0]    out_level_r;
  adsr_pkg::phase_t              out_phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_sample_r <= prod[adsr_pkg::LEVEL_FRAC_BITS +: SAMPLE_BITS];
      out_level_r  <= s1_st_r.level;
      out_phase_r  <= s1_st_r.phase;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_env_level  = out_level_r;
  assign out_env_phase  = out_phase_r;

  // Checks
  a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.level <= adsr_pkg::UNITY)
    else $error("envelope level above unity");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == adsr_pkg::PH_IDLE) |-> (st_r.level == '0))
    else $error("idle phase with nonzero level");

  a_sustain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_req_type == adsr_pkg::REQ_SAMPLE && st_r.phase == adsr_pkg::PH_SUSTAIN)
    |=> (st_r.level == adsr_pkg::sat_unity(cfg_r.hold_level)))
    else $error("sustain did not hold level");

  a_note_on: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_req_type == adsr_pkg::REQ_NOTE_ON) |=> (st_r.phase == adsr_pkg::PH_ATTACK))
    else $error("note-on did not enter attack");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_valid_r && !out_ready) |=> (s1_v_r && $stable(s1_st_r)))
    else $error("stage 1 lost an item under stall");

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the linear ADSR envelope generator.
`timescale 1ns / 1ps

module testbench;

  localparam int SMP_W          = 16;
  localparam int PROD_W         = SMP_W + adsr_pkg::LVL_W + 1;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer or register write
  localparam int DRAIN_CYCLES   = 8;     // extra cycles after the queues run empty, as margin
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_ITEMS   = 950;
  localparam int NUM_PHASES     = 8;

  // Request code the block must ignore: no state change, no transfer out.
  localparam logic [1:0] REQ_RESERVED = 2'd3;

  localparam logic [adsr_pkg::LVL_W-1:0] CFG_ALL_ONES = '1;

  // Register values after reset
  localparam logic [adsr_pkg::LVL_W-1:0] RST_ATTACK_STEP  = 24'd175;
  localparam logic [adsr_pkg::LVL_W-1:0] RST_PEAK_LEVEL   = adsr_pkg::UNITY;
  localparam logic [adsr_pkg::LVL_W-1:0] RST_DECAY_STEP   = 24'd0;
  localparam logic [adsr_pkg::LVL_W-1:0] RST_HOLD_LEVEL   = adsr_pkg::UNITY;
  localparam logic [adsr_pkg::LVL_W-1:0] RST_RELEASE_STEP = 24'd175;

  // One input transfer
  typedef struct packed {
    logic [1:0]              req;
    logic signed [SMP_W-1:0] smp;
  } env_req_t;

  // One output transfer
  typedef struct packed {
    logic signed [SMP_W-1:0]     smp;
    logic [adsr_pkg::LVL_W-1:0]  level;
    adsr_pkg::phase_t            phase;
  } env_out_t;

  // ---------------------------------------------------------------------------
  // DUT ports; every input is known from time zero
  // ---------------------------------------------------------------------------
  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;

  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              in_req_type = adsr_pkg::REQ_SAMPLE;
  logic signed [SMP_W-1:0] in_sample_in = '0;

  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [SMP_W-1:0] out_sample_out;
  logic [adsr_pkg::LVL_W-1:0] out_env_level;
  logic [2:0]              out_env_phase;

  logic                    cfg_we = 1'b0;
  logic [adsr_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [adsr_pkg::LVL_W-1:0]     cfg_wdata = '0;

  adsr_envelope_generator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .out_env_level  (out_env_level),
    .out_env_phase  (out_env_phase),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Envelope predictor: own copy of the registers, phase and level
  // ---------------------------------------------------------------------------
  adsr_pkg::env_cfg_t         shape;
  adsr_pkg::phase_t           env_phase = adsr_pkg::PH_IDLE;
  logic [adsr_pkg::LVL_W-1:0] env_level = '0;

  env_req_t req_q[$];      // requests waiting for the driver
  env_out_t gained_q[$];   // predicted scaled samples, oldest first
  int       pending_reqs;  // queued but not yet transferred
  int       queued_items;  // requests queued in the current phase, reserved code excluded
  int       idle_pct;      // sender idle chance per cycle, percent
  int       stall_pct;     // receiver stall chance per cycle, percent
  int       errors;
  int       quiet_cycles;

  // Apply one accepted request to the predictor; audio samples queue a result.
  function automatic void predict_request(input logic [1:0] req,
                                          input logic signed [SMP_W-1:0] smp);
    logic [adsr_pkg::LVL_W-1:0]    peak;
    logic [adsr_pkg::LVL_W-1:0]    hold;
    logic [adsr_pkg::LVL_W:0]      sum;
    logic signed [PROD_W-1:0]      prod;
    env_out_t                      res;
    // level registers above unity act as unity
    peak = (shape.peak_level > adsr_pkg::UNITY) ? adsr_pkg::UNITY : shape.peak_level;
    hold = (shape.hold_level > adsr_pkg::UNITY) ? adsr_pkg::UNITY : shape.hold_level;
    case (req)
      adsr_pkg::REQ_NOTE_ON:  env_phase = adsr_pkg::PH_ATTACK;   // attack starts from the current level
      adsr_pkg::REQ_NOTE_OFF: env_phase = adsr_pkg::PH_RELEASE;  // also from idle
      adsr_pkg::REQ_SAMPLE: begin
        case (env_phase)
          adsr_pkg::PH_ATTACK: begin
            sum = {1'b0, env_level} + {1'b0, shape.attack_step};
            if (sum >= {1'b0, peak}) begin
              env_level = peak;
              env_phase = adsr_pkg::PH_DECAY;
            end else begin
              env_level = sum[adsr_pkg::LVL_W-1:0];
            end
          end
          adsr_pkg::PH_DECAY: begin
            // a level already below hold snaps up to hold
            if (env_level <= hold || env_level - hold <= shape.decay_step) begin
              env_level = hold;
              env_phase = adsr_pkg::PH_SUSTAIN;
            end else begin
              env_level = env_level - shape.decay_step;
            end
          end
          adsr_pkg::PH_SUSTAIN: env_level = hold;
          adsr_pkg::PH_RELEASE: begin
            if (env_level <= shape.release_step) begin
              env_level = '0;
              env_phase = adsr_pkg::PH_IDLE;
            end else begin
              env_level = env_level - shape.release_step;
            end
          end
          default: ;
        endcase
        // floor of sample * level / 2^23
        prod      = PROD_W'($signed(smp)) * PROD_W'($signed({1'b0, env_level}));
        prod      = prod >>> adsr_pkg::LEVEL_FRAC_BITS;
        res.smp   = prod[SMP_W-1:0];
        res.level = env_level;
        res.phase = env_phase;
        gained_q.push_back(res);
      end
      default: ;  // reserved code
    endcase
  endfunction

  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: launches queued requests, idles at random between transfers
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    env_req_t nxt_req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (req_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt_req      = req_q.pop_front();
        in_valid     <= 1'b1;
        in_req_type  <= nxt_req.req;
        in_sample_in <= nxt_req.smp;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on input transfers, checks output transfers, stalls the
  // result channel at random and watches for a hang.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    env_out_t exp_out;
    if (!rst_n) begin
      out_ready    <= 1'b0;
      quiet_cycles = 0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);

      if (in_valid && in_ready) begin
        predict_request(in_req_type, in_sample_in);
        pending_reqs--;
      end

      if (out_valid && out_ready) begin
        if (gained_q.size() == 0) begin
          flag_error($sformatf("unexpected transfer: sample %0d level %0d phase %0d",
                               out_sample_out, out_env_level, out_env_phase));
        end else begin
          exp_out = gained_q.pop_front();
          if (out_sample_out !== exp_out.smp || out_env_level !== exp_out.level ||
              out_env_phase !== exp_out.phase) begin
            flag_error($sformatf({"mismatch: expected sample %0d level %0d phase %0d,",
                                  " got sample %0d level %0d phase %0d"},
                                 exp_out.smp, exp_out.level, exp_out.phase,
                                 out_sample_out, out_env_level, out_env_phase));
          end
        end
      end

      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_req(input logic [1:0] req,
                                    input logic signed [SMP_W-1:0] smp);
    env_req_t r;
    r.req = req;
    r.smp = smp;
    req_q.push_back(r);
    pending_reqs++;
    if (req != REQ_RESERVED) queued_items++;
  endfunction

  // Full-scale and near-zero values show up often
  function automatic logic signed [SMP_W-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return {1'b0, {(SMP_W-1){1'b1}}};
      1:       return {1'b1, {(SMP_W-1){1'b0}}};
      2:       return '0;
      3:       return '1;
      default: return SMP_W'($urandom);
    endcase
  endfunction

  // Mostly steps that run a phase out in a handful of samples
  function automatic logic [adsr_pkg::LVL_W-1:0] pick_step();
    case ($urandom_range(9))
      0:       return '0;
      1:       return CFG_ALL_ONES;
      2:       return adsr_pkg::UNITY;
      3:       return adsr_pkg::LVL_W'($urandom_range(1, 255));
      default: return adsr_pkg::LVL_W'($urandom_range(adsr_pkg::UNITY >> 4,
                                                      adsr_pkg::UNITY >> 1));
    endcase
  endfunction

  function automatic logic [adsr_pkg::LVL_W-1:0] pick_level();
    case ($urandom_range(7))
      0:       return '0;
      1:       return CFG_ALL_ONES;
      2:       return adsr_pkg::UNITY;
      3:       return adsr_pkg::LVL_W'($urandom);  // often above unity
      default: return adsr_pkg::LVL_W'($urandom_range(0, adsr_pkg::UNITY));
    endcase
  endfunction

  // Register write; the predictor copy follows at once since nothing is in flight.
  task automatic write_reg(input logic [adsr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [adsr_pkg::LVL_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      adsr_pkg::CFG_ATTACK_STEP:  shape.attack_step  = val;
      adsr_pkg::CFG_PEAK_LEVEL:   shape.peak_level   = val;
      adsr_pkg::CFG_DECAY_STEP:   shape.decay_step   = val;
      adsr_pkg::CFG_HOLD_LEVEL:   shape.hold_level   = val;
      adsr_pkg::CFG_RELEASE_STEP: shape.release_step = val;
      default: ;  // unmapped index, ignored
    endcase
  endtask

  task automatic program_shape(input logic [adsr_pkg::LVL_W-1:0] atk,
                               input logic [adsr_pkg::LVL_W-1:0] pk,
                               input logic [adsr_pkg::LVL_W-1:0] dec,
                               input logic [adsr_pkg::LVL_W-1:0] hld,
                               input logic [adsr_pkg::LVL_W-1:0] rel);
    write_reg(adsr_pkg::CFG_ATTACK_STEP, atk);
    write_reg(adsr_pkg::CFG_PEAK_LEVEL, pk);
    write_reg(adsr_pkg::CFG_DECAY_STEP, dec);
    write_reg(adsr_pkg::CFG_HOLD_LEVEL, hld);
    write_reg(adsr_pkg::CFG_RELEASE_STEP, rel);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sender holds off until every predicted result has been transferred out.
  task automatic wait_drained();
    while (pending_reqs != 0 || gained_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One note: on, some samples, off, release tail. Some are cut short,
  // retriggered or left hanging; a few are plain noise.
  task automatic queue_phrase();
    int n;
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(1, 4);
      repeat (n) queue_req(2'($urandom_range(3)), pick_sample());
    end else begin
      queue_req(adsr_pkg::REQ_NOTE_ON, pick_sample());
      n = $urandom_range(0, 30);
      repeat (n) queue_req(adsr_pkg::REQ_SAMPLE, pick_sample());
      if ($urandom_range(5) == 0) begin
        // retrigger before the note is released
        queue_req(adsr_pkg::REQ_NOTE_ON, pick_sample());
        n = $urandom_range(0, 8);
        repeat (n) queue_req(adsr_pkg::REQ_SAMPLE, pick_sample());
      end
      if ($urandom_range(7) != 0) queue_req(adsr_pkg::REQ_NOTE_OFF, pick_sample());
      n = $urandom_range(0, 14);
      repeat (n) queue_req(adsr_pkg::REQ_SAMPLE, pick_sample());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    shape.attack_step  = RST_ATTACK_STEP;
    shape.peak_level   = RST_PEAK_LEVEL;
    shape.decay_step   = RST_DECAY_STEP;
    shape.hold_level   = RST_HOLD_LEVEL;
    shape.release_step = RST_RELEASE_STEP;
    pending_reqs = 0;
    queued_items = 0;
    idle_pct     = 0;
    stall_pct    = 0;
    errors       = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset register values: slow attack and release, level climbs by 175
    queue_req(adsr_pkg::REQ_NOTE_ON, '0);
    queue_req(adsr_pkg::REQ_SAMPLE, 16'sh7fff);
    queue_req(adsr_pkg::REQ_SAMPLE, 16'sh8000);
    queue_req(adsr_pkg::REQ_NOTE_OFF, '0);
    queue_req(adsr_pkg::REQ_SAMPLE, -16'sd1);
    queue_req(adsr_pkg::REQ_SAMPLE, 16'sd1);  // release reaches zero, back to idle
    wait_drained();

    // Unmapped indexes must not disturb the shape
    for (int i = int'(adsr_pkg::CFG_RELEASE_STEP) + 1; i < 2 ** adsr_pkg::CFG_IDX_W; i++) begin
      write_reg(adsr_pkg::CFG_IDX_W'(i), CFG_ALL_ONES);
    end
    // Quarter-step attack to unity, eighth-step decay to half, quarter release
    program_shape(adsr_pkg::UNITY >> 2, adsr_pkg::UNITY, adsr_pkg::UNITY >> 3,
                  adsr_pkg::UNITY >> 1, adsr_pkg::UNITY >> 2);

    queue_req(adsr_pkg::REQ_NOTE_OFF, '0);         // note-off while idle
    queue_req(adsr_pkg::REQ_SAMPLE, 16'sd7);       // release from zero returns to idle
    queue_req(REQ_RESERVED, -16'sd1);              // ignored
    queue_req(adsr_pkg::REQ_NOTE_ON, '0);
    queue_req(adsr_pkg::REQ_SAMPLE, 16'sh7fff);
    queue_req(adsr_pkg::REQ_SAMPLE, 16'sh8000);
    queue_req(adsr_pkg::REQ_SAMPLE, -16'sd1);
    queue_req(adsr_pkg::REQ_SAMPLE, 16'sh8000);    // clamps at peak, decay begins
    repeat (4) queue_req(adsr_pkg::REQ_SAMPLE, 16'sh7fff);  // decay down onto the hold level
    queue_req(adsr_pkg::REQ_SAMPLE, 16'sd0);       // sustain
    queue_req(adsr_pkg::REQ_NOTE_OFF, '0);
    queue_req(adsr_pkg::REQ_SAMPLE, 16'sd1);
    queue_req(adsr_pkg::REQ_NOTE_ON, '0);          // attack from the released level
    queue_req(adsr_pkg::REQ_SAMPLE, -16'sd2);
    queue_req(adsr_pkg::REQ_NOTE_OFF, '0);
    queue_req(adsr_pkg::REQ_SAMPLE, 16'sh4000);
    queue_req(adsr_pkg::REQ_SAMPLE, 16'sh4000);    // release ends at zero
    wait_drained();

    // Random phases, each under its own shape and one of four idling modes
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       program_shape(CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES,
                               CFG_ALL_ONES);
        1:       program_shape('0, '0, '0, '0, '0);
        default: program_shape(pick_step(), pick_level(), pick_step(), pick_level(),
                               pick_step());
      endcase
      case (p % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 64; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 64; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      queued_items = 0;
      while (queued_items < RANDOM_ITEMS / NUM_PHASES) queue_phrase();
      wait_drained();
    end

    if (errors == 0 && gained_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
